### rtl/evg_pkg.sv
// ----------------------------------------------------------------------------
// evg_pkg
// shared types and constants of the ellipse vertex generator
// ----------------------------------------------------------------------------
package evg_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES    = 30;
    localparam int COUNT_W          = 7;
    localparam int INDEX_W          = 6;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;
    localparam logic [31:0]        PI_FIFTH_Q32    = 32'd2698607541;
    localparam logic [COUNT_W-1:0] MIN_COUNT       = 7'd3;
    localparam logic [COUNT_W-1:0] MAX_DERIVED     = 7'd127;

    localparam logic signed [31:0] ATAN_TURN [CORDIC_STAGES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
        32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
        32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215,
        32'sd2608, 32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81,
        32'sd41, 32'sd20, 32'sd10, 32'sd5, 32'sd3, 32'sd1
    };

    typedef struct packed {
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic [30:0]         rx;
        logic [30:0]         ry;
        logic [COUNT_W-1:0]  n;
        logic [31:0]         step;
    } t_desc;

    typedef struct packed {
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic [30:0]         rx;
        logic [30:0]         ry;
        logic                last;
        logic [1:0]          quad;
        logic                zero;
    } t_vtx;

endpackage

### rtl/evg_front.sv
// ----------------------------------------------------------------------------
// evg_front
// takes input words, derives the vertex count and the angle step
// ----------------------------------------------------------------------------
module evg_front import evg_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [30:0]        i_radius_x,
    input  logic [30:0]        i_radius_y,
    input  logic [6:0]         i_segment_count,
    output logic               o_push,
    output t_desc              o_desc,
    input  logic               i_full
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CNT, S_DIV, S_PUSH} t_state;

    t_state             r_state;
    logic signed [31:0] r_cx, r_cy;
    logic [30:0]        r_rx, r_ry;
    logic [6:0]         r_cnt_in;
    logic [62:0]        r_prod;
    logic [COUNT_W-1:0] r_n;
    logic [COUNT_W-1:0] r_rem;
    logic [31:0]        r_q;
    logic [5:0]         r_bit;

    logic [30:0]        rmax;
    logic [14:0]        d;
    logic [COUNT_W-1:0] derived, n_pick, n_sat;
    logic [COUNT_W:0]   shifted;
    logic               q_bit;

    assign rmax    = (r_rx > r_ry) ? r_rx : r_ry;
    assign d       = r_prod[62:48];
    assign derived = (d < 15'(MIN_COUNT)) ? MIN_COUNT :
                     ((d > 15'(MAX_DERIVED)) ? MAX_DERIVED : d[COUNT_W-1:0]);
    assign n_pick  = (r_cnt_in == '0) ? derived : r_cnt_in;
    assign n_sat   = (n_pick > COUNT_W'(MAX_SEGMENTS)) ? COUNT_W'(MAX_SEGMENTS) : n_pick;
    assign shifted = {r_rem, (r_bit == 6'd32)};
    assign q_bit   = (shifted >= {1'b0, r_n});

    assign o_stall = (r_state != S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;
    assign o_desc  = '{cx: r_cx, cy: r_cy, rx: r_rx, ry: r_ry, n: r_n, step: r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cx     <= i_center_x;
                        r_cy     <= i_center_y;
                        r_rx     <= i_radius_x;
                        r_ry     <= i_radius_y;
                        r_cnt_in <= i_segment_count;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 63'(rmax) * 63'(PI_FIFTH_Q32);
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    r_n   <= n_sat;
                    r_rem <= '0;
                    r_bit <= 6'd32;
                    if (r_rx == '0 && r_ry == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= q_bit ? COUNT_W'(shifted - {1'b0, r_n}) : shifted[COUNT_W-1:0];
                    r_q   <= {r_q[30:0], q_bit};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == '0) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/evg_queue.sv
// ----------------------------------------------------------------------------
// evg_queue
// two-entry queue of run descriptors between front and back
// ----------------------------------------------------------------------------
module evg_queue import evg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### rtl/evg_back.sv
// ----------------------------------------------------------------------------
// evg_back
// steps through the vertices of a run, cordic pipeline, scale and offset
// ----------------------------------------------------------------------------
module evg_back import evg_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_desc              i_desc,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_last_point
);

    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic               en;
    t_desc              r_desc;
    logic               r_busy;
    logic [INDEX_W-1:0] r_idx;
    logic [31:0]        r_acc;
    logic [31:0]        turn;

    logic               r_sv [CORDIC_STAGES+1];
    logic signed [33:0] r_x  [CORDIC_STAGES+1];
    logic signed [33:0] r_y  [CORDIC_STAGES+1];
    logic signed [31:0] r_z  [CORDIC_STAGES+1];
    t_vtx               r_p  [CORDIC_STAGES+1];

    logic               r_mv, r_pv;
    t_vtx               r_mp, r_pp;
    logic signed [33:0] r_c, r_s;
    logic signed [33:0] cq, sq;
    logic signed [65:0] r_px, r_py;
    logic signed [65:0] rx_sum, ry_sum;
    logic               r_out_valid;

    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && !r_busy && i_q_valid;
    assign turn  = r_acc & ANGLE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_sv[0] <= 1'b0;
        end else if (en) begin
            if (r_busy) begin
                r_sv[0] <= 1'b1;
                r_idx   <= r_idx + 1'b1;
                r_acc   <= r_acc + r_desc.step;
                if ({1'b0, r_idx} + 7'd1 == r_desc.n) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_sv[0] <= 1'b0;
                if (i_q_valid) begin
                    r_desc <= i_desc;
                    r_busy <= 1'b1;
                    r_idx  <= '0;
                    r_acc  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0] <= CORDIC_GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= $signed({2'b00, turn[29:0]});
            r_p[0] <= '{cx: r_desc.cx, cy: r_desc.cy, rx: r_desc.rx, ry: r_desc.ry,
                        last: ({1'b0, r_idx} + 7'd1 == r_desc.n),
                        quad: turn[31:30], zero: (turn[29:0] == '0)};
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic signed [33:0] dx, dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p[k+1] <= r_p[k];
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - ATAN_TURN[k];
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + ATAN_TURN[k];
                end
            end
        end
    end

    assign cq = r_p[CORDIC_STAGES].zero ? ONE_Q30 : r_x[CORDIC_STAGES];
    assign sq = r_p[CORDIC_STAGES].zero ? '0 : r_y[CORDIC_STAGES];

    assign rx_sum = r_px + 66'sd536870912;
    assign ry_sum = r_py + 66'sd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv        <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_mv        <= r_sv[CORDIC_STAGES];
            r_pv        <= r_mv;
            r_out_valid <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mp <= r_p[CORDIC_STAGES];
            case (r_p[CORDIC_STAGES].quad)
                2'd0: begin
                    r_c <= cq;
                    r_s <= sq;
                end
                2'd1: begin
                    r_c <= -sq;
                    r_s <= cq;
                end
                2'd2: begin
                    r_c <= -cq;
                    r_s <= -sq;
                end
                default: begin
                    r_c <= sq;
                    r_s <= -cq;
                end
            endcase
            r_pp <= r_mp;
            r_px <= 66'($signed({1'b0, r_mp.rx})) * 66'(r_c);
            r_py <= 66'($signed({1'b0, r_mp.ry})) * 66'(r_s);
            o_point_x    <= r_pp.cx + $signed(rx_sum[61:30]);
            o_point_y    <= r_pp.cy + $signed(ry_sum[61:30]);
            o_last_point <= r_pp.last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

### rtl/ellipse_vertex_generator.sv
// ----------------------------------------------------------------------------
// ellipse_vertex_generator
// ellipse and circle vertex generator, q16.16 coordinates
// ----------------------------------------------------------------------------
// the front runs a count multiply, then a 33-step divider; each vertex then
// passes through the cordic pipeline and the scale and offset registers
// the n vertices of a run leave one per cycle while i_stall is low; a new word
// is taken only while the front is idle, also while the back still streams a run
// reset: synchronous active low, clears queue, sequencer and valid bits
// ----------------------------------------------------------------------------
module ellipse_vertex_generator import evg_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [30:0]        i_radius_x,
    input  logic [30:0]        i_radius_y,
    input  logic [6:0]         i_segment_count,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_last_point
);

    logic  push, full, pop, q_valid;
    t_desc push_desc, pop_desc;

    evg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_radius_x(i_radius_x), .i_radius_y(i_radius_y),
        .i_segment_count(i_segment_count),
        .o_push(push), .o_desc(push_desc), .i_full(full)
    );

    evg_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_desc(push_desc),
        .o_full(full), .i_pop(pop), .o_valid(q_valid), .o_desc(pop_desc)
    );

    evg_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_desc(pop_desc),
        .o_pop(pop), .o_valid(o_valid), .i_stall(i_stall),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_last_point(o_last_point)
    );

endmodule

### rtl/evg_checker.sv
// ----------------------------------------------------------------------------
// evg_checker
// port-level checks of the ellipse vertex generator
// ----------------------------------------------------------------------------
module evg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_point_x,
    input logic [31:0] o_point_y,
    input logic        o_last_point
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("front took a second word while busy");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_point_x) && $stable(o_point_y)
        && $stable(o_last_point)))
        else $error("stalled output word changed");

endmodule

bind ellipse_vertex_generator evg_checker u_evg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_point_x(o_point_x),
    .o_point_y(o_point_y), .o_last_point(o_last_point)
);
